[rtl/assert_macros.svh]
// Assertion macros used by refcounted_service_table_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/rst_pkg.sv]
`default_nettype none
package rst_pkg;
  localparam int Entries    = 32;
  localparam int CountBits  = 16;
  localparam int KeyBits    = 32;
  localparam int IdxBits    = $clog2(Entries);
  localparam int InBits     = 104;
  localparam int OutBits    = 136;

  localparam logic [2:0] OP_ADD_PUB = 3'd0;
  localparam logic [2:0] OP_ADD_SRV = 3'd1;
  localparam logic [2:0] OP_REM_PUB = 3'd2;
  localparam logic [2:0] OP_REM_SRV = 3'd3;
  localparam logic [2:0] OP_PURGE   = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

  // One table entry as it travels along the ring.
  typedef struct packed {
    logic                 valid;
    logic [KeyBits-1:0]   svc;
    logic [KeyBits-1:0]   inst;
    logic [KeyBits-1:0]   evt;
    logic [CountBits-1:0] pub;
    logic [CountBits-1:0] srv;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic write;
    logic clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/rst_cell.sv]
`default_nettype none
module rst_cell (
  input  wire logic           clk,
  input  wire rst_pkg::cell_ctl_t ctl,
  input  wire rst_pkg::entry_t    prev,
  input  wire rst_pkg::entry_t    wdata,
  output rst_pkg::entry_t         q
);
  rst_pkg::entry_t ent_r;
  rst_pkg::entry_t ent_nxt;

  // A cell takes its neighbor's entry on a shift, or new contents on a write; a clear drops its valid bit.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = prev;
    end else if (ctl.write) begin
      ent_nxt = wdata;
    end
    if (ctl.clear) begin
      ent_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;
endmodule
`default_nettype wire

[rtl/refcounted_service_table_top.sv]
// Channel | Direction | Payload
// in_     | slave     | tdata: op, service_id, instance_id, event_id, use_service,
//         |           |        use_instance, use_event
// out_    | master    | tdata: status, found, out_service, out_instance, out_event,
//         |           |        publishers, servers, changed; tlast: last
// Every item makes one full turn of the entry ring: a scan step per cell, then
// an update, then one result per cycle while out_tready is high.
// Reset clears all valid bits at once.
// Output stalls hold the result register; no new item enters until done.
`default_nettype none
`include "assert_macros.svh"
module refcounted_service_table_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // op[2:0], service_id[34:3], instance_id[66:35], event_id[98:67],
  // use_service[99], use_instance[100], use_event[101], zero fill
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], found[2], out_service[34:3], out_instance[66:35],
  // out_event[98:67], publishers[114:99], servers[130:115], changed[131], zero fill
  output logic [135:0]      out_tdata,
  output logic              out_tlast
);
  localparam int N = rst_pkg::Entries;
  localparam int IB = rst_pkg::IdxBits;
  localparam int OutBitsW = 131;

  rst_pkg::state_t state_r, state_nxt;
  rst_pkg::entry_t cell_q [N];
  rst_pkg::cell_ctl_t ctl [N];
  rst_pkg::entry_t wdata;

  logic [2:0]  op_r;
  logic [31:0] s_r, i_r, e_r;
  logic        us_r, ui_r, ue_r;
  logic [IB:0] cnt_r, cnt_nxt;
  // Found key slot and first free slot, recorded during the walk.
  logic        hit_r, hit_nxt, free_v_r, free_v_nxt;
  logic [IB-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic        hint_v_r, hint_v_nxt;
  logic [IB-1:0] hint_idx_r, hint_idx_nxt;
  logic        chg_r, chg_nxt;
  // Result queue for query matches.
  logic [OutBitsW-1:0] q_mem [N];
  logic [IB:0] qn_r, qn_nxt, qrd_r, qrd_nxt;
  logic [OutBitsW-1:0] qw;
  logic qwe;
  logic [1:0]  st_r, st_nxt;
  logic        ch_out_r, ch_out_nxt;
  logic [OutBitsW-1:0] rd_q;

  // Cells form a ring; slot index of the head is cnt mod N during the scan.
  for (genvar g = 0; g < N; g++) begin : g_cell
    rst_cell u_cell (
      .clk  (clk),
      .ctl  (ctl[g]),
      .prev (cell_q[(g + 1) % N]),
      .wdata(wdata),
      .q    (cell_q[g])
    );
  end

  rst_pkg::entry_t head;
  logic [IB-1:0] slot;
  logic key_eq, match;
  logic [IB-1:0] tgt;
  logic do_write;
  logic [rst_pkg::CountBits-1:0] cpub, csrv;

  assign head = cell_q[0];
  assign slot = cnt_r[IB-1:0];
  assign key_eq = head.valid && head.svc == s_r && head.inst == i_r && head.evt == e_r;
  assign match = head.valid && (!us_r || head.svc == s_r) && (!ui_r || head.inst == i_r)
                 && (!ue_r || head.evt == e_r);
  assign qw = {head.srv, head.pub, head.evt, head.inst, head.svc, 1'b1, rst_pkg::ST_OK};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r; hit_idx_nxt = hit_idx_r;
    free_v_nxt = free_v_r; free_idx_nxt = free_idx_r;
    hint_v_nxt = hint_v_r; hint_idx_nxt = hint_idx_r;
    chg_nxt = chg_r;
    qn_nxt = qn_r; qrd_nxt = qrd_r;
    st_nxt = st_r; ch_out_nxt = ch_out_r;
    qwe = 1'b0;
    do_write = 1'b0;
    tgt = hit_idx_r;
    wdata = cell_q[hit_idx_r];
    cpub = wdata.pub; csrv = wdata.srv;
    for (int k = 0; k < N; k++) ctl[k] = '{shift: 1'b0, write: 1'b0, clear: 1'b0};
    unique case (state_r)
      rst_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rst_pkg::S_SCAN;
          cnt_nxt = '0; hit_nxt = 1'b0; free_v_nxt = 1'b0; qn_nxt = '0; qrd_nxt = '0;
          st_nxt = rst_pkg::ST_OK; ch_out_nxt = 1'b0;
        end
      end
      rst_pkg::S_SCAN: begin
        for (int k = 0; k < N; k++) ctl[k].shift = 1'b1;
        if (key_eq && !hit_r) begin
          hit_nxt = 1'b1; hit_idx_nxt = slot;
        end
        if (!head.valid && !free_v_r) begin
          free_v_nxt = 1'b1; free_idx_nxt = slot;
        end
        if (op_r == rst_pkg::OP_QUERY && match) begin
          qwe = 1'b1; qn_nxt = qn_r + 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (IB+1)'(N - 1)) state_nxt = rst_pkg::S_APPLY;
      end
      rst_pkg::S_APPLY: begin
        state_nxt = rst_pkg::S_OUT;
        case (op_r)
          rst_pkg::OP_ADD_PUB, rst_pkg::OP_ADD_SRV: begin
            if (hit_r) begin
              if ((op_r == rst_pkg::OP_ADD_PUB ? cpub : csrv) == '1) begin
                st_nxt = rst_pkg::ST_SAT;
              end else begin
                if (op_r == rst_pkg::OP_ADD_PUB) wdata.pub = cpub + 1'b1;
                else wdata.srv = csrv + 1'b1;
                do_write = 1'b1; chg_nxt = 1'b1;
              end
            end else begin
              hint_v_nxt = 1'b0;
              if (hint_v_r && !cell_q[hint_idx_r].valid) begin
                tgt = hint_idx_r; do_write = 1'b1;
              end else if (free_v_r) begin
                tgt = free_idx_r; do_write = 1'b1;
              end else begin
                st_nxt = rst_pkg::ST_FULL;
              end
              wdata.valid = 1'b1; wdata.svc = s_r; wdata.inst = i_r; wdata.evt = e_r;
              wdata.pub = (op_r == rst_pkg::OP_ADD_PUB) ? 16'd1 : 16'd0;
              wdata.srv = (op_r == rst_pkg::OP_ADD_SRV) ? 16'd1 : 16'd0;
              if (do_write) chg_nxt = 1'b1;
            end
          end
          rst_pkg::OP_REM_PUB, rst_pkg::OP_REM_SRV: begin
            if (hit_r && (op_r == rst_pkg::OP_REM_PUB ? cpub : csrv) != '0) begin
              if (op_r == rst_pkg::OP_REM_PUB) wdata.pub = cpub - 1'b1;
              else wdata.srv = csrv - 1'b1;
              do_write = 1'b1;
              if (wdata.pub == '0 && wdata.srv == '0) begin
                wdata.valid = 1'b0; chg_nxt = 1'b1;
                hint_v_nxt = 1'b1; hint_idx_nxt = hit_idx_r;
              end
            end
          end
          rst_pkg::OP_PURGE: begin
            if (hit_r) begin
              wdata.valid = 1'b0; do_write = 1'b1; chg_nxt = 1'b1;
              hint_v_nxt = 1'b1; hint_idx_nxt = hit_idx_r;
            end
          end
          rst_pkg::OP_READ: begin
            ch_out_nxt = chg_r; chg_nxt = 1'b0;
          end
          default: ;
        endcase
        for (int k = 0; k < N; k++) ctl[k].write = do_write && tgt == IB'(k);
      end
      rst_pkg::S_OUT: begin
        if (out_tready && out_tlast) state_nxt = rst_pkg::S_IDLE;
        if (out_tready) qrd_nxt = qrd_r + 1'b1;
      end
      default: state_nxt = rst_pkg::S_IDLE;
    endcase
    if (!rst_n) for (int k = 0; k < N; k++) ctl[k].clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rst_pkg::S_IDLE;
      hint_v_r <= 1'b0;
      chg_r <= 1'b0;
      cnt_r <= '0;
      qn_r <= '0;
      qrd_r <= '0;
    end else begin
      state_r <= state_nxt;
      hint_v_r <= hint_v_nxt;
      chg_r <= chg_nxt;
      cnt_r <= cnt_nxt;
      qn_r <= qn_nxt;
      qrd_r <= qrd_nxt;
    end
  end

  // Payload registers, the walk and status registers, and the result memory.
  always_ff @(posedge clk) begin
    if (state_r == rst_pkg::S_IDLE && in_tvalid) begin
      op_r <= in_tdata[2:0];
      s_r <= in_tdata[34:3]; i_r <= in_tdata[66:35]; e_r <= in_tdata[98:67];
      us_r <= in_tdata[99]; ui_r <= in_tdata[100]; ue_r <= in_tdata[101];
    end
    hit_r <= hit_nxt; hit_idx_r <= hit_idx_nxt;
    free_v_r <= free_v_nxt; free_idx_r <= free_idx_nxt;
    hint_idx_r <= hint_idx_nxt;
    st_r <= st_nxt; ch_out_r <= ch_out_nxt;
    if (qwe) q_mem[qn_r[IB-1:0]] <= qw;
  end

  // The result memory is read combinationally only through a registered index.
  logic [IB:0] rd_idx;
  assign rd_idx = qrd_r;
  assign rd_q = q_mem[rd_idx[IB-1:0]];

  logic is_q;
  assign is_q = op_r == rst_pkg::OP_QUERY && qn_r != '0;
  assign in_tready = state_r == rst_pkg::S_IDLE;
  assign out_tvalid = state_r == rst_pkg::S_OUT;
  assign out_tlast = is_q ? (qrd_r + 1'b1 == qn_r) : 1'b1;
  assign out_tdata = is_q ? {5'd0, rd_q}
                          : {4'd0, ch_out_r, 129'd0, st_r};

  `ASSERT_IMPLIES(a_single_out, clk, rst_n, out_tvalid && !is_q, out_tlast)
  `ASSERT_IMPLIES(a_q_bound, clk, rst_n, out_tvalid && is_q, qrd_r < qn_r)
  `ASSERT_NEXT(a_scan_len, clk, rst_n, state_r == rst_pkg::S_APPLY,
               state_r == rst_pkg::S_OUT)
endmodule
`default_nettype wire

[tb/sv/tb_refcounted_service_table_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_refcounted_service_table_top;

  localparam logic [2:0] OpNone = 3'd7;
  localparam int CycleLimit = 2000000;

  // One expected result transaction.
  typedef struct packed {
    logic [1:0]                    status;
    logic                          found;
    logic [rst_pkg::KeyBits-1:0]   svc;
    logic [rst_pkg::KeyBits-1:0]   inst;
    logic [rst_pkg::KeyBits-1:0]   evt;
    logic [rst_pkg::CountBits-1:0] pub;
    logic [rst_pkg::CountBits-1:0] srv;
    logic                          changed;
    logic                          last;
  } table_result_t;

  // One request transaction plus an optional hand-typed result.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] svc;
    logic [31:0] inst;
    logic [31:0] evt;
    logic [2:0]  use_mask;
    bit          typed;
    logic [1:0]  typed_status;
    logic        typed_changed;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [103:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic in_tready, out_tvalid, out_tlast;
  logic [135:0] out_tdata;

  refcounted_service_table_top i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  always #5 clk = ~clk;

  // Shadow copy of the table.
  logic                          sh_valid [rst_pkg::Entries];
  logic [rst_pkg::KeyBits-1:0]   sh_svc [rst_pkg::Entries];
  logic [rst_pkg::KeyBits-1:0]   sh_inst [rst_pkg::Entries];
  logic [rst_pkg::KeyBits-1:0]   sh_evt [rst_pkg::Entries];
  logic [rst_pkg::CountBits-1:0] sh_pub [rst_pkg::Entries];
  logic [rst_pkg::CountBits-1:0] sh_srv [rst_pkg::Entries];
  bit                            sh_hint_ok;
  int                            sh_hint;
  bit                            sh_changed;

  table_result_t pending_results [$];
  request_t      directed_rows [$];
  int  idle_pct, stall_pct;
  bit  failed = 1'b0;
  int  cycle_count = 0;

  function automatic int find_key(logic [31:0] s, logic [31:0] i, logic [31:0] e);
    for (int k = 0; k < rst_pkg::Entries; k++)
      if (sh_valid[k] && sh_svc[k] == s && sh_inst[k] == i && sh_evt[k] == e) return k;
    return -1;
  endfunction

  function automatic void release_slot(int k);
    sh_valid[k] = 1'b0;
    sh_hint_ok = 1'b1;
    sh_hint = k;
    sh_changed = 1'b1;
  endfunction

  // Applies one request to the shadow table and queues the results it causes.
  function automatic void predict_table(request_t rq);
    table_result_t r;
    int k, n, slot;
    k = find_key(rq.svc, rq.inst, rq.evt);
    r = '0;
    r.last = 1'b1;
    if (rq.op == rst_pkg::OP_QUERY) begin
      n = 0;
      for (int j = 0; j < rst_pkg::Entries && n < 32; j++) begin
        if (!sh_valid[j]) continue;
        if (rq.use_mask[0] && sh_svc[j] != rq.svc) continue;
        if (rq.use_mask[1] && sh_inst[j] != rq.inst) continue;
        if (rq.use_mask[2] && sh_evt[j] != rq.evt) continue;
        r = '0;
        r.found = 1'b1;
        r.svc = sh_svc[j];
        r.inst = sh_inst[j];
        r.evt = sh_evt[j];
        r.pub = sh_pub[j];
        r.srv = sh_srv[j];
        pending_results.push_back(r);
        n++;
      end
      if (n == 0) begin
        r = '0;
        pending_results.push_back(r);
      end
      pending_results[$].last = 1'b1;
      return;
    end
    case (rq.op)
      rst_pkg::OP_ADD_PUB, rst_pkg::OP_ADD_SRV: begin
        if (k >= 0) begin
          if (rq.op == rst_pkg::OP_ADD_PUB) begin
            if (&sh_pub[k]) r.status = rst_pkg::ST_SAT;
            else begin sh_pub[k]++; sh_changed = 1'b1; end
          end else begin
            if (&sh_srv[k]) r.status = rst_pkg::ST_SAT;
            else begin sh_srv[k]++; sh_changed = 1'b1; end
          end
        end else begin
          slot = -1;
          if (sh_hint_ok && !sh_valid[sh_hint]) slot = sh_hint;
          else
            for (int j = 0; j < rst_pkg::Entries; j++)
              if (!sh_valid[j]) begin slot = j; break; end
          sh_hint_ok = 1'b0;
          if (slot < 0) r.status = rst_pkg::ST_FULL;
          else begin
            sh_valid[slot] = 1'b1;
            sh_svc[slot] = rq.svc;
            sh_inst[slot] = rq.inst;
            sh_evt[slot] = rq.evt;
            sh_pub[slot] = {{(rst_pkg::CountBits-1){1'b0}}, rq.op == rst_pkg::OP_ADD_PUB};
            sh_srv[slot] = {{(rst_pkg::CountBits-1){1'b0}}, rq.op == rst_pkg::OP_ADD_SRV};
            sh_changed = 1'b1;
          end
        end
      end
      rst_pkg::OP_REM_PUB, rst_pkg::OP_REM_SRV: begin
        if (k >= 0) begin
          if (rq.op == rst_pkg::OP_REM_PUB && sh_pub[k] != 0) begin
            sh_pub[k]--;
            if (sh_pub[k] == 0 && sh_srv[k] == 0) release_slot(k);
          end else if (rq.op == rst_pkg::OP_REM_SRV && sh_srv[k] != 0) begin
            sh_srv[k]--;
            if (sh_pub[k] == 0 && sh_srv[k] == 0) release_slot(k);
          end
        end
      end
      rst_pkg::OP_PURGE: if (k >= 0) release_slot(k);
      rst_pkg::OP_READ: begin
        r.changed = sh_changed;
        sh_changed = 1'b0;
      end
      default: ;
    endcase
    if (rq.typed && (r.status != rq.typed_status || r.changed != rq.typed_changed)) begin
      $error("directed row: predictor gives status %0d changed %0d, table says %0d %0d",
             r.status, r.changed, rq.typed_status, rq.typed_changed);
      failed = 1'b1;
    end
    pending_results.push_back(r);
  endfunction

  // Sends one request; the prediction is made at acceptance. The valid line is
  // dropped only while the sender idles, so each edge sees a single update.
  task automatic send_request(request_t rq);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, rq.use_mask, rq.evt, rq.inst, rq.svc, rq.op};
    do @(posedge clk); while (!in_tready);
    predict_table(rq);
  endtask

  function automatic request_t make_request(logic [2:0] op, logic [31:0] s, logic [31:0] i,
                                            logic [31:0] e, logic [2:0] m);
    request_t rq;
    rq = '{op: op, svc: s, inst: i, evt: e, use_mask: m, typed: 1'b0,
           typed_status: rst_pkg::ST_OK, typed_changed: 1'b0};
    return rq;
  endfunction

  function automatic request_t make_typed(logic [2:0] op, logic [31:0] s, logic [1:0] st,
                                          logic ch);
    request_t rq;
    rq = make_request(op, s, 32'd0, 32'd0, 3'b000);
    rq.typed = 1'b1;
    rq.typed_status = st;
    rq.typed_changed = ch;
    return rq;
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    table_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status: out_tdata[1:0], found: out_tdata[2], svc: out_tdata[34:3],
              inst: out_tdata[66:35], evt: out_tdata[98:67], pub: out_tdata[114:99],
              srv: out_tdata[130:115], changed: out_tdata[131], last: out_tlast};
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); failed = 1'b1;
        end
        if (got.found !== want.found) begin
          $error("found expected %0d actual %0d", want.found, got.found); failed = 1'b1;
        end
        if (got.svc !== want.svc) begin
          $error("out_service expected %h actual %h", want.svc, got.svc); failed = 1'b1;
        end
        if (got.inst !== want.inst) begin
          $error("out_instance expected %h actual %h", want.inst, got.inst); failed = 1'b1;
        end
        if (got.evt !== want.evt) begin
          $error("out_event expected %h actual %h", want.evt, got.evt); failed = 1'b1;
        end
        if (got.pub !== want.pub) begin
          $error("publishers expected %0d actual %0d", want.pub, got.pub); failed = 1'b1;
        end
        if (got.srv !== want.srv) begin
          $error("servers expected %0d actual %0d", want.srv, got.srv); failed = 1'b1;
        end
        if (got.changed !== want.changed) begin
          $error("changed expected %0d actual %0d", want.changed, got.changed);
          failed = 1'b1;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, got.last); failed = 1'b1;
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stalls.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Random key drawn from a small pool so that hits are common, with some noise.
  function automatic logic [31:0] pick_id(int pool);
    if ($urandom_range(9) == 0) return $urandom;
    return 32'hA5A5_0000 ^ 32'($urandom_range(pool));
  endfunction

  initial begin
    request_t rq;
    int pool;
    logic [2:0] op;
    idle_pct = 0;
    stall_pct = 0;
    for (int k = 0; k < rst_pkg::Entries; k++) begin
      sh_valid[k] = 1'b0; sh_svc[k] = '0; sh_inst[k] = '0; sh_evt[k] = '0;
      sh_pub[k] = '0; sh_srv[k] = '0;
    end
    sh_hint_ok = 1'b0;
    sh_hint = 0;
    sh_changed = 1'b0;

    // Directed rows: empty table, extremes, every op, and the odd cases.
    directed_rows.push_back(make_typed(rst_pkg::OP_READ, 32'd0, rst_pkg::ST_OK, 1'b0));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 3'b000));
    directed_rows.push_back(make_typed(rst_pkg::OP_REM_PUB, 32'd0, rst_pkg::ST_OK, 1'b0));
    directed_rows.push_back(make_typed(rst_pkg::OP_PURGE, 32'd0, rst_pkg::ST_OK, 1'b0));
    directed_rows.push_back(make_typed(OpNone, 32'd0, rst_pkg::ST_OK, 1'b0));
    directed_rows.push_back(make_request(rst_pkg::OP_ADD_PUB, '1, '1, '1, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_ADD_SRV, '1, '1, '1, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_ADD_SRV, 32'd0, 32'd0, 32'd0, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_ADD_PUB, '1, 32'd0, '1, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, '1, '1, '1, 3'b111));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, '1, 32'd5, 32'd5, 3'b001));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, 32'd9, 32'd0, 32'd7, 3'b010));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, 32'd9, 32'd9, '1, 3'b100));
    directed_rows.push_back(make_typed(rst_pkg::OP_READ, 32'd0, rst_pkg::ST_OK, 1'b1));
    directed_rows.push_back(make_request(rst_pkg::OP_REM_PUB, '1, '1, '1, 3'b000));
    directed_rows.push_back(make_typed(rst_pkg::OP_READ, 32'd0, rst_pkg::ST_OK, 1'b0));
    directed_rows.push_back(make_request(rst_pkg::OP_REM_SRV, '1, '1, '1, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_REM_SRV, '1, '1, '1, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_PURGE, 32'd0, 32'd0, 32'd0, 3'b000));
    directed_rows.push_back(make_typed(rst_pkg::OP_READ, 32'd0, rst_pkg::ST_OK, 1'b1));
    // The slot just freed by the purge is taken again by this add.
    directed_rows.push_back(make_request(rst_pkg::OP_ADD_SRV, 32'h1234_5678, 32'h9ABC_DEF0,
                                         32'h0F0F_0F0F, 3'b000));
    directed_rows.push_back(make_request(rst_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 3'b000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n]) send_request(directed_rows[n]);

    // Fill the table to its limit; the last three of these adds report full.
    for (int k = 0; k < rst_pkg::Entries + 1; k++)
      send_request(make_request(rst_pkg::OP_ADD_PUB, 32'hF000_0000 + k, 32'd1, 32'd2,
                                3'b000));
    send_request(make_request(rst_pkg::OP_QUERY, 32'd0, 32'd1, 32'd2, 3'b110));
    send_request(make_request(rst_pkg::OP_PURGE, 32'hF000_0007, 32'd1, 32'd2, 3'b000));
    send_request(make_request(rst_pkg::OP_ADD_SRV, 32'hF000_0040, 32'd1, 32'd2, 3'b000));
    send_request(make_request(rst_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 3'b000));
    for (int k = 0; k < rst_pkg::Entries + 1; k++)
      send_request(make_request(rst_pkg::OP_PURGE, 32'hF000_0000 + k, 32'd1, 32'd2,
                                3'b000));
    send_request(make_request(rst_pkg::OP_PURGE, 32'hF000_0040, 32'd1, 32'd2, 3'b000));

    // One key's publisher count climbs a little; reaching saturation would take
    // far more adds than the run allows.
    for (int k = 0; k < 20; k++)
      send_request(make_request(rst_pkg::OP_ADD_PUB, 32'h0BAD_CAFE, 32'd3, 32'd4, 3'b000));

    // Random part in four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      pool = (phase == 3) ? 60 : 12;
      for (int n = 0; n < 85; n++) begin
        op = 3'($urandom_range(99) < 40 ? $urandom_range(1) : $urandom_range(7));
        rq = make_request(op, pick_id(pool), pick_id(2), pick_id(2), 3'($urandom_range(7)));
        send_request(rq);
      end
    end
    in_tvalid <= 1'b0;

    // Drain.
    idle_pct = 0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/rst_pkg.sv
rtl/rst_cell.sv
rtl/refcounted_service_table_top.sv
tb/sv/tb_refcounted_service_table_top.sv
